/* rtl/core/gmq_pkg.sv */
// ----------------------------------------------------------------------------
// Group min/max quantiser package
// Shared types, widths and the fp16 to fixed-point conversion.
// ----------------------------------------------------------------------------
package gmq_pkg;

   // Finite fp16 values in units of 2^-24 need 41 bits with sign; one spare.
   localparam int FIX_W  = 42;
   // Numerator (value offset times levels) needs up to 49 bits.
   localparam int NUM_W  = 51;
   localparam int CODE_W = 8;

   localparam logic MODE_NIBBLE = 1'b0;
   localparam logic MODE_BYTE   = 1'b1;

   localparam logic [CODE_W-1:0] LEVELS_NIBBLE = 8'd15;
   localparam logic [CODE_W-1:0] LEVELS_BYTE   = 8'd255;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic signed [FIX_W:0]   key_type;

   // One completed group handed from the front to the back.
   typedef struct packed {
      logic [15:0] low;
      logic [15:0] high;
      logic        mode;
      logic        bank;
   } desc_type;

   // Non-finite patterns saturate to the largest finite magnitude.
   function automatic fix_type half_to_fixed(input logic [15:0] h);
      logic [4:0]       e;
      logic [9:0]       m;
      logic [FIX_W-1:0] mag;
      e = h[14:10];
      m = h[9:0];
      if (e == 5'd31) begin
         e = 5'd30;
         m = 10'h3FF;
      end
      if (e == 5'd0) begin
         mag = {{(FIX_W-10){1'b0}}, m};
      end else begin
         mag = {{(FIX_W-11){1'b0}}, 1'b1, m} << (e - 5'd1);
      end
      return h[15] ? fix_type'(-mag) : fix_type'(mag);
   endfunction

   // Ordering key: value order, with minus zero just below plus zero.
   function automatic key_type order_key(input logic [15:0] h);
      key_type k;
      k = {half_to_fixed(h), 1'b0};
      return k - key_type'({{FIX_W{1'b0}}, h[15]});
   endfunction

endpackage

/* rtl/core/group_minmax_quantizer.sv */
// ----------------------------------------------------------------------------
// Group min/max quantiser
// Groupwise asymmetric fp16 to 4-bit or 8-bit quantiser with min/max tracking.
// ----------------------------------------------------------------------------
// Samples arrive one per cycle and are written into a two-bank sample RAM
// while the front tracks the group minimum and maximum. When a group is
// complete its minimum, maximum, the code width mode and its bank are queued,
// and the back quantises the stored group while the front fills the other
// bank. Each code is computed exactly in fixed point: the offset from the
// minimum times the level count is divided by the range in a restoring
// divider that produces one quotient bit per cycle, then rounded to nearest
// with ties to even and clamped. A code that ends a byte passes through RAM
// read, load, eight divider steps, rounding and emit; the first code of a
// nibble pair has no emit of its own. A group whose range is zero skips the
// divider. For each group the back first takes it from the queue and forms
// its range, and it works on one code at a time, holding in emit while the
// output is stalled. Input is taken at one sample per cycle until two groups
// are outstanding, after which the input stalls until the back finishes its
// current group. The code width mode is captured with the sample that
// completes a group.
module group_minmax_quantizer #(
   parameter int GROUP_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_half_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_code_byte,
   output logic [15:0] rsp_group_low,
   output logic [15:0] rsp_group_high,
   output logic        rsp_end_of_group,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import gmq_pkg::*;

   localparam int AW = $clog2(GROUP_SIZE) + 1;

   logic          mode_ff, mode_in;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic          push, pop, q_not_empty, q_full, grp_done;
   desc_type      push_data, pop_data;

   // The mode register resets to 4-bit packed codes.
   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NIBBLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   gmq_front #(.GROUP_SIZE(GROUP_SIZE)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_half_value (req_half_value),
      .mode           (mode_ff),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .push           (push),
      .push_data      (push_data),
      .grp_done       (grp_done)
   );

   // Two banks of one group each: the front fills one while the back reads
   // the other.
   gmq_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   gmq_back #(.GROUP_SIZE(GROUP_SIZE)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .pop              (pop),
      .pop_data         (pop_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .grp_done         (grp_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_group_low    (rsp_group_low),
      .rsp_group_high   (rsp_group_high),
      .rsp_end_of_group (rsp_end_of_group)
   );

   // A full queue means two groups wait, so the front must be stalled.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset) q_full |-> req_stall)
      else $error("input open while two groups are queued");

endmodule

/* rtl/core/gmq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/gmq_queue.sv */
// ----------------------------------------------------------------------------
// Group descriptor queue
// Two-entry queue carrying completed groups from the front to the back.
// ----------------------------------------------------------------------------
module gmq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gmq_pkg::desc_type push_data,
   input  logic              pop,
   output gmq_pkg::desc_type pop_data,
   output logic              not_empty,
   output logic              full
);
   import gmq_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("group queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("group queue read while empty");

endmodule

/* rtl/core/gmq_front.sv */
// ----------------------------------------------------------------------------
// Quantiser front
// Accepts samples, stores them and tracks the group minimum and maximum.
// ----------------------------------------------------------------------------
module gmq_front #(
   parameter int GROUP_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [15:0]                   req_half_value,
   input  logic                          mode,
   output logic                          wr_en,
   output logic [$clog2(GROUP_SIZE):0]   wr_addr,
   output logic [15:0]                   wr_data,
   output logic                          push,
   output gmq_pkg::desc_type             push_data,
   input  logic                          grp_done
);
   import gmq_pkg::*;

   localparam int IW = $clog2(GROUP_SIZE);
   localparam logic [IW-1:0] LAST = IW'(GROUP_SIZE - 1);

   logic [IW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic [15:0]   low_ff, low_in;
   logic [15:0]   high_ff, high_in;
   logic [1:0]    pend_ff, pend_in;
   logic          accept;
   key_type       key;

   assign req_stall = (pend_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign key       = order_key(req_half_value);

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (accept) begin
         if (fill_ff == '0) begin
            low_in  = req_half_value;
            high_in = req_half_value;
         end else begin
            // Strict compares keep the earlier sample on an exact tie.
            if (key < order_key(low_ff)) begin
               low_in = req_half_value;
            end
            if (key > order_key(high_ff)) begin
               high_in = req_half_value;
            end
         end
         if (fill_ff == LAST) begin
            fill_in = '0;
            bank_in = !bank_ff;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      pend_in = pend_ff + {1'b0, push} - {1'b0, grp_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         pend_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         pend_ff <= pend_in;
      end
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   assign wr_en          = accept;
   assign wr_addr        = {bank_ff, fill_ff};
   assign wr_data        = req_half_value;
   assign push           = accept && (fill_ff == LAST);
   assign push_data.low  = low_in;
   assign push_data.high = high_in;
   assign push_data.mode = mode;
   assign push_data.bank = bank_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset) pend_ff != 2'd3)
      else $error("more than two groups outstanding");

endmodule

/* rtl/core/gmq_back.sv */
// ----------------------------------------------------------------------------
// Quantiser back
// Reads a stored group, divides each offset times the level count by the range
// (skipped when the range is zero) and emits bytes.
module gmq_back #(
   parameter int GROUP_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   output logic                          pop,
   input  gmq_pkg::desc_type             pop_data,
   output logic                          rd_en,
   output logic [$clog2(GROUP_SIZE):0]   rd_addr,
   input  logic [15:0]                   rd_data,
   output logic                          grp_done,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_code_byte,
   output logic [15:0]                   rsp_group_low,
   output logic [15:0]                   rsp_group_high,
   output logic                          rsp_end_of_group
);
   import gmq_pkg::*;

   localparam int IW = $clog2(GROUP_SIZE);
   localparam logic [IW-1:0] LAST = IW'(GROUP_SIZE - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_READ, S_LOAD, S_DIV, S_ROUND, S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   desc_type          desc_ff, desc_in;
   fix_type           lo_ff, lo_in;
   logic [FIX_W-1:0]  range_ff, range_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [7:0]        quo_ff, quo_in;
   logic [2:0]        step_ff, step_in;
   logic [3:0]        nib_ff, nib_in;
   logic [7:0]        byte_ff, byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_code_ff, rsp_code_in;
   logic [15:0]       rsp_low_ff, rsp_low_in;
   logic [15:0]       rsp_high_ff, rsp_high_in;
   logic              rsp_end_ff, rsp_end_in;

   // One bit wider than a value: the offset spans the full range.
   logic signed [FIX_W:0] diff;
   logic [NUM_W-1:0]  d_ext;
   logic [NUM_W-1:0]  shifted;
   logic [FIX_W:0]    rem2;
   logic [8:0]        q_round;
   logic [7:0]        levels;
   logic [7:0]        code;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign levels   = (desc_ff.mode == MODE_BYTE) ? LEVELS_BYTE : LEVELS_NIBBLE;

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      lo_in        = lo_ff;
      range_in     = range_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      nib_in       = nib_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_end_in   = rsp_end_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      grp_done     = 1'b0;

      diff = (FIX_W+1)'(half_to_fixed(rd_data)) - (FIX_W+1)'(lo_ff);
      if (diff[FIX_W]) begin
         d_ext = '0;
      end else begin
         d_ext = NUM_W'(diff[FIX_W-1:0]);
      end
      shifted = NUM_W'(range_ff) << step_ff;
      rem2    = {rem_ff[FIX_W-1:0], 1'b0};
      q_round = {1'b0, quo_ff};
      if (rem2 > {1'b0, range_ff} || (rem2 == {1'b0, range_ff} && quo_ff[0])) begin
         q_round = q_round + 9'd1;
      end
      if (q_round > {1'b0, levels}) begin
         code = levels;
      end else begin
         code = q_round[7:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               desc_in  = pop_data;
               idx_in   = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            lo_in    = half_to_fixed(desc_ff.low);
            range_in = FIX_W'(half_to_fixed(desc_ff.high) - half_to_fixed(desc_ff.low));
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            quo_in  = '0;
            step_in = 3'd7;
            if (range_ff == '0) begin
               rem_in   = '0;
               state_in = S_ROUND;
            end else begin
               if (desc_ff.mode == MODE_BYTE) begin
                  rem_in = (d_ext << 8) - d_ext;
               end else begin
                  rem_in = (d_ext << 4) - d_ext;
               end
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ff >= shifted) begin
               rem_in          = rem_ff - shifted;
               quo_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            if (desc_ff.mode == MODE_BYTE) begin
               byte_in  = code;
               state_in = S_EMIT;
            end else if (!idx_ff[0] && idx_ff != LAST) begin
               nib_in   = code[3:0];
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end else if (!idx_ff[0]) begin
               byte_in  = {4'h0, code[3:0]};
               state_in = S_EMIT;
            end else begin
               byte_in  = {code[3:0], nib_ff};
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = byte_ff;
               rsp_low_in   = desc_ff.low;
               rsp_high_in  = desc_ff.high;
               rsp_end_in   = (idx_ff == LAST);
               if (idx_ff == LAST) begin
                  grp_done = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff     <= desc_in;
      lo_ff       <= lo_in;
      range_ff    <= range_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      nib_ff      <= nib_in;
      byte_ff     <= byte_in;
      rsp_code_ff <= rsp_code_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rd_addr          = {desc_ff.bank, idx_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_byte    = rsp_code_ff;
   assign rsp_group_low    = rsp_low_ff;
   assign rsp_group_high   = rsp_high_ff;
   assign rsp_end_of_group = rsp_end_ff;

   a_done_from_emit: assert property (@(posedge clock) disable iff (reset)
      grp_done |-> (state_ff == S_EMIT && idx_ff == LAST))
      else $error("group finished away from its last byte");

endmodule
